>>> sv/sha256_stream_hasher_core_defines.svh
// assertion helpers for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SHA_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

>>> sv/sha_pkg.sv
package sha_pkg;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef struct packed {
		logic       fin;
		logic [7:0] data;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} sha_state_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

>>> sv/sha_front.sv
module sha_front
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sha_item_t in_item,
	output logic      q_valid,
	input  logic      q_pop,
	output sha_item_t q_item
);
	sha_item_t      mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           push;

	assign in_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(q_pop);
		end
	end

	`include "sha256_stream_hasher_core_defines.svh"
	`SHA_ASSERT(a_no_over, cnt_q == (QAW+1)'(QDEPTH) |-> !push, "queue overflow")
	`SHA_ASSERT_NEVER(a_no_under, q_pop && cnt_q == '0, "queue underflow")
	`SHA_ASSERT(a_cnt, push && !q_pop |=> cnt_q == $past(cnt_q) + 1'b1, "count slip")
endmodule

>>> sv/sha_back.sv
module sha_back
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  sha_item_t   q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_idx,
	output logic        out_last
);
	sha_state_t  st_q, st_n;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] bits_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        fin_q, padded_q;
	logic [2:0]  oi_q;
	logic        pend_q;
	logic [7:0]  fb;
	logic        fill_go, blk_done;
	logic [31:0] s0, s1, t1, t2, e, a;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE, ST_FILL: begin
				if (fill_go && fill_q == 6'd63) st_n = ST_ROUND;
				else if (fill_go) st_n = ST_FILL;
				else st_n = ST_IDLE;
			end
			ST_ROUND: if (rnd_q == 6'd63) st_n = ST_ADD;
			ST_ADD: begin
				if (pend_q) st_n = ST_EMIT;
				else if (fin_q) st_n = ST_FILL;
				else st_n = ST_IDLE;
			end
			ST_EMIT: if (out_ready && oi_q == 3'd7) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		fill_go = 1'b0;
		fb = q_item.data;
		unique case (st_q)
			ST_IDLE, ST_FILL: begin
				if (fin_q) begin
					fill_go = 1'b1;
					if (padded_q && fill_q >= 6'd56) fb = bits_q[{~fill_q[2:0], 3'b000} +: 8];
					else fb = 8'h00;
				end else if (q_valid) begin
					fill_go = 1'b1;
					q_pop = !q_item.fin;
					if (q_item.fin) fb = 8'h80;
				end
			end
			default: ;
		endcase
	end

	// padded_q: the length may go into the current block
	assign blk_done = fin_q && padded_q && fill_q == 6'd63;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + RC[rnd_q] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (fill_go) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= fb;
		end
		if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
			bits_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			padded_q <= 1'b0;
			oi_q <= '0;
			pend_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (fill_go) begin
				fill_q <= fill_q + 1'b1;
				if (!fin_q && q_item.fin) begin
					fin_q <= 1'b1;
					padded_q <= (fill_q < 6'd56);
				end else if (!fin_q) begin
					bits_q <= bits_q + 64'd8;
				end
				if (blk_done) pend_q <= 1'b1;
			end
			if (st_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
			if (st_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				if (fin_q) padded_q <= 1'b1;
			end
			if (st_q == ST_EMIT && out_ready) begin
				oi_q <= oi_q + 1'b1;
				if (oi_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
					bits_q <= '0;
					fin_q <= 1'b0;
					padded_q <= 1'b0;
					pend_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = (st_q == ST_EMIT);
	assign out_word = h_q[oi_q];
	assign out_idx = oi_q;
	assign out_last = (oi_q == 3'd7);

	`include "sha256_stream_hasher_core_defines.svh"
	`SHA_ASSERT(a_emit_idle, out_valid && out_ready && out_last |=> !out_valid, "emit overrun")
	`SHA_ASSERT_NEVER(a_pop_busy, q_pop && st_q == ST_ROUND, "pop during rounds")
	`SHA_ASSERT(a_round_run, st_q == ST_ROUND && rnd_q != 6'd63 |=> st_q == ST_ROUND, "round break")
endmodule

>>> sv/sha256_stream_hasher_core.sv
// a pad byte at byte 56 or later needs a second padding block before the digest
// blocks: 64 byte beats fill a block, then 64 rounds and one add step run on it
// no new bytes are taken while the single round unit runs; the front queue buffers up to four
// digest: eight beats, one per cycle while the sink is ready
// reset: arst_n clears queue and control and loads the initial hash words
module sha256_stream_hasher_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word, word_index, zero fill
	output logic        m_axis_tlast   // last_word
);
	sha_item_t   in_item, q_item;
	logic        q_valid, q_pop;
	logic        q_pop_all, fin_pop;
	logic [31:0] w;
	logic [2:0]  idx;

	assign in_item.fin = s_axis_tuser;
	assign in_item.data = s_axis_tdata;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_pop(q_pop_all), .q_item
	);

	assign fin_pop = m_axis_tvalid && m_axis_tready && m_axis_tlast;
	assign q_pop_all = q_pop || fin_pop;

	sha_back u_back (
		.clk, .arst_n,
		.q_valid, .q_pop, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(w), .out_idx(idx), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, idx, w};
endmodule
